@@ hdl/nsc_pkg.sv @@
// Package for the NMEA sentence checker: result codes, the result record,
// the sentence type table and the hex digit decoder. No dependencies.
package nsc_pkg;

    // Control characters and delimiters.
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_COMMA = 8'h2C;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_NO_DELIM = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OVERLONG = 3'd4
    } t_status;

    // Sentence type codes.
    typedef enum logic [2:0] {
        KD_GGA   = 3'd0,
        KD_GSA   = 3'd1,
        KD_GSV   = 3'd2,
        KD_RMC   = 3'd3,
        KD_VTG   = 3'd4,
        KD_OTHER = 3'd5
    } t_kind;

    localparam int NUM_KINDS = 5;

    // Last three letters of each recognised first field, in code order.
    localparam logic [23:0] KIND_LETTERS [NUM_KINDS] = '{
        24'h474741, 24'h475341, 24'h475356, 24'h524D43, 24'h565447
    };

    // One result beat.
    typedef struct packed {
        t_status     status;
        t_kind       kind;
        logic [5:0]  field_count;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
    } t_result;

    // Decoded hex digit with a flag for characters that are not hex.
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

@@ hdl/nsc_parser.sv @@
// Sentence state and result formation for the NMEA sentence checker.
// Depends on nsc_pkg.
module nsc_parser #(
    parameter int MAX_LEN    = 128,
    parameter int MAX_FIELDS = 63
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_produce,
    output nsc_pkg::t_result  o_result
);
    import nsc_pkg::*;

    localparam logic [7:0] LEN_LIMIT   = 8'(MAX_LEN);
    localparam logic [5:0] FIELD_LIMIT = 6'(MAX_FIELDS);

    logic        r_started,   n_started;
    logic        r_seen_star, n_seen_star;
    logic [7:0]  r_xor_acc,   n_xor_acc;
    logic [1:0]  r_hex_seen,  n_hex_seen;
    logic [7:0]  r_hex_value, n_hex_value;
    logic        r_hex_bad,   n_hex_bad;
    logic [7:0]  r_line_len,  n_line_len;
    logic        r_overlong,  n_overlong;
    logic [5:0]  r_sep_count, n_sep_count;
    logic [23:0] r_type,      n_type;
    logic [3:0]  r_ffl,       n_ffl;

    t_hex        hex;
    logic [6:0]  field_sum;
    t_kind       kind;

    assign hex = hex_decode(i_byte);

    // Next sentence state for the byte in the input register.
    always_comb begin
        n_started   = r_started;
        n_seen_star = r_seen_star;
        n_xor_acc   = r_xor_acc;
        n_hex_seen  = r_hex_seen;
        n_hex_value = r_hex_value;
        n_hex_bad   = r_hex_bad;
        n_line_len  = r_line_len;
        n_overlong  = r_overlong;
        n_sep_count = r_sep_count;
        n_type      = r_type;
        n_ffl       = r_ffl;
        priority if (i_byte == CHR_CR) begin
            // Carriage return leaves everything as it is.
        end else if (i_byte == CHR_LF) begin
            n_started   = 1'b0;
            n_seen_star = 1'b0;
            n_xor_acc   = '0;
            n_hex_seen  = '0;
            n_hex_value = '0;
            n_hex_bad   = 1'b0;
            n_line_len  = '0;
            n_overlong  = 1'b0;
            n_sep_count = '0;
            n_type      = '0;
            n_ffl       = '0;
        end else begin
            if (r_line_len >= LEN_LIMIT) begin
                n_overlong = 1'b1;
            end else begin
                n_line_len = r_line_len + 8'd1;
            end
            priority if (i_byte == CHR_DOLLAR) begin
                // A dollar restarts the sentence but keeps the line length.
                n_started   = 1'b1;
                n_seen_star = 1'b0;
                n_xor_acc   = '0;
                n_hex_seen  = '0;
                n_hex_value = '0;
                n_hex_bad   = 1'b0;
                n_sep_count = '0;
                n_type      = '0;
                n_ffl       = '0;
            end else if (!r_started) begin
                // Bytes before the dollar count only towards the length.
            end else if (!r_seen_star) begin
                if (i_byte == CHR_STAR) begin
                    n_seen_star = 1'b1;
                    if (r_sep_count < FIELD_LIMIT) n_sep_count = r_sep_count + 6'd1;
                end else begin
                    n_xor_acc = r_xor_acc ^ i_byte;
                    if (i_byte == CHR_COMMA) begin
                        if (r_sep_count < FIELD_LIMIT) n_sep_count = r_sep_count + 6'd1;
                    end else if (r_sep_count == '0) begin
                        if (r_ffl != 4'hF) n_ffl = r_ffl + 4'd1;
                        n_type = {r_type[15:0], i_byte};
                    end
                end
            end else if (r_hex_seen != 2'd2) begin
                // Checksum digit; a non-hex character counts as zero and is flagged.
                n_hex_value = {r_hex_value[3:0], hex.value};
                n_hex_bad   = r_hex_bad | hex.bad;
                n_hex_seen  = r_hex_seen + 2'd1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_seen_star <= 1'b0;
            r_xor_acc   <= '0;
            r_hex_seen  <= '0;
            r_hex_value <= '0;
            r_hex_bad   <= 1'b0;
            r_line_len  <= '0;
            r_overlong  <= 1'b0;
            r_sep_count <= '0;
            r_type      <= '0;
            r_ffl       <= '0;
        end else if (i_fire) begin
            r_started   <= n_started;
            r_seen_star <= n_seen_star;
            r_xor_acc   <= n_xor_acc;
            r_hex_seen  <= n_hex_seen;
            r_hex_value <= n_hex_value;
            r_hex_bad   <= n_hex_bad;
            r_line_len  <= n_line_len;
            r_overlong  <= n_overlong;
            r_sep_count <= n_sep_count;
            r_type      <= n_type;
            r_ffl       <= n_ffl;
        end
    end

    // Sentence type lookup over the five known types.
    always_comb begin
        kind = KD_OTHER;
        if (r_ffl == 4'd5) begin
            for (int k = NUM_KINDS - 1; k >= 0; k--) begin
                if (r_type == KIND_LETTERS[k]) kind = t_kind'(3'(k));
            end
        end
    end

    assign field_sum = {1'b0, r_sep_count} + 7'd1;

    // Result for a line feed that ends a non-empty line.
    always_comb begin
        o_result.kind         = kind;
        o_result.computed_sum = r_xor_acc;
        o_result.received_sum = r_hex_value;
        if (!r_started) begin
            o_result.field_count = '0;
        end else if (field_sum > {1'b0, FIELD_LIMIT}) begin
            o_result.field_count = FIELD_LIMIT;
        end else begin
            o_result.field_count = field_sum[5:0];
        end
        priority if (r_overlong) begin
            o_result.status = ST_OVERLONG;
        end else if (!r_started || !r_seen_star) begin
            o_result.status = ST_NO_DELIM;
        end else if (r_hex_bad || r_hex_seen != 2'd2 || r_hex_value != r_xor_acc) begin
            o_result.status = ST_MISMATCH;
        end else if (kind == KD_OTHER) begin
            o_result.status = ST_UNKNOWN;
        end else begin
            o_result.status = ST_VALID;
        end
    end

    assign o_produce = (i_byte == CHR_LF) && (r_line_len != '0);

endmodule

@@ hdl/nsc_out_reg.sv @@
// Result register with valid/stall handshake for the NMEA sentence checker.
// Depends on nsc_pkg.
module nsc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  nsc_pkg::t_result  i_result,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output nsc_pkg::t_result  o_result
);
    import nsc_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    // Space is free when empty or when the held beat leaves this cycle.
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) r_result <= i_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/nmea_sentence_checker_core.sv @@
// NMEA sentence checker, top level: input byte register, parser and result register.
// Depends on nsc_pkg, nsc_parser and nsc_out_reg.
//
// Takes one received character per beat and gives one result beat for every line
// feed that ends a non-empty line. A byte can be accepted in every cycle: it is
// held in an input register, and when it moves on the sentence state is updated
// from it while a line feed's result is loaded into the result register, from
// which the result beat is offered. The only back-pressure is on a line feed
// that makes a result while the result register holds a beat that is stalled;
// every other byte passes at full rate. No clearing after reset is needed.
module nmea_sentence_checker_core #(
    parameter int MAX_LEN    = 128,
    parameter int MAX_FIELDS = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [2:0] o_status,
    output logic [2:0] o_sentence_type,
    output logic [5:0] o_field_count,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum
);
    import nsc_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       fire;
    logic       produce;
    logic       out_ready;
    logic       in_accept;
    t_result    result;
    t_result    out_result;

    // The held byte moves on unless its result finds the result register blocked.
    assign fire       = r_in_valid && (!produce || out_ready);
    assign o_rx_stall = r_in_valid && !fire;
    assign in_accept  = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_in_byte <= i_rx_byte;
    end

    nsc_parser #(
        .MAX_LEN    (MAX_LEN),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .o_produce (produce),
        .o_result  (result)
    );

    nsc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && produce),
        .i_result (result),
        .i_stall  (i_res_stall),
        .o_ready  (out_ready),
        .o_valid  (o_res_valid),
        .o_result (out_result)
    );

    assign o_status        = out_result.status;
    assign o_sentence_type = out_result.kind;
    assign o_field_count   = out_result.field_count;
    assign o_computed_sum  = out_result.computed_sum;
    assign o_received_sum  = out_result.received_sum;

    // A valid sentence always carries matching checksums.
    a_valid_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == ST_VALID) |-> (o_computed_sum == o_received_sum))
        else $error("valid status with differing checksums");

    // A valid sentence is always of a recognised type.
    a_valid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == ST_VALID) |-> (o_sentence_type != KD_OTHER))
        else $error("valid status with unrecognised type");

    // A sentence that got past the delimiter checks has at least one field.
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == ST_VALID || o_status == ST_MISMATCH
            || o_status == ST_UNKNOWN)) |-> (o_field_count != 6'd0))
        else $error("delimited sentence with no fields");

    // A byte held back is only ever a line feed that makes a result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (produce && o_res_valid && i_res_stall))
        else $error("input stalled without a blocked result");

endmodule
